[src/dtf_pkg.sv]
// Package for the decimal text to fixed-point converter.
// Holds the widths, character codes, payload and job structs and the power-of-ten table.
// Used by every module of the block; depends on nothing.
package dtf_pkg;

  // Format of the result.
  localparam int INT_BITS        = 31;
  localparam int FRAC_BITS       = 16;
  localparam int MAX_FRAC_DIGITS = 9;
  localparam int VALUE_W         = 48;

  // Internal widths.
  localparam int FRAC_NUM_W = 30;   // nine decimal digits fit
  localparam int FRAC_CNT_W = 4;
  localparam int DIV_W      = 30;   // widest power of ten used
  localparam int REM_W      = DIV_W + 1;
  localparam int STEP_W     = $clog2(FRAC_BITS);
  localparam int PROD_W     = INT_BITS + 4;

  // Magnitude clamp.
  localparam int TOTAL_BITS = INT_BITS + FRAC_BITS;
  localparam int SUM_W      = TOTAL_BITS + 1;
  localparam int CAP_BITS   = (TOTAL_BITS >= VALUE_W - 1) ? VALUE_W - 1 : TOTAL_BITS;
  localparam logic [SUM_W-1:0] MAG_CAP = (SUM_W'(1) << CAP_BITS) - SUM_W'(1);
  localparam logic [INT_BITS-1:0] INT_LIMIT = {INT_BITS{1'b1}};

  // Queue between the parser and the formatter.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Character codes.
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef struct packed {
    logic [7:0] ch;
    logic       start_req;
  } in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      saturated;
  } out_t;

  // One finished number handed from the parser to the formatter.
  typedef struct packed {
    logic                  zero;
    logic                  negative;
    logic                  overflow;
    logic [INT_BITS-1:0]   int_acc;
    logic [FRAC_NUM_W-1:0] frac_num;
    logic [FRAC_CNT_W-1:0] frac_digits;
  } job_t;

  function automatic logic [DIV_W-1:0] pow10(input logic [FRAC_CNT_W-1:0] k);
    logic [DIV_W-1:0] r;
    case (k)
      4'd0:    r = DIV_W'(1);
      4'd1:    r = DIV_W'(10);
      4'd2:    r = DIV_W'(100);
      4'd3:    r = DIV_W'(1000);
      4'd4:    r = DIV_W'(10000);
      4'd5:    r = DIV_W'(100000);
      4'd6:    r = DIV_W'(1000000);
      4'd7:    r = DIV_W'(10000000);
      4'd8:    r = DIV_W'(100000000);
      4'd9:    r = DIV_W'(1000000000);
      default: r = DIV_W'(1);
    endcase
    return r;
  endfunction

endpackage

[src/dtf_front.sv]
// Character parser: skips whitespace, tracks sign, integer and fraction digits.
// Emits one job per terminated number towards the queue. Depends on dtf_pkg.
module dtf_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  dtf_pkg::in_t  in_data,
  output logic          push_valid,
  input  logic          push_ready,
  output dtf_pkg::job_t push_job
);
  import dtf_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_WS   = 5'b00010,
    PH_SIGN = 5'b00100,
    PH_INT  = 5'b01000,
    PH_FRAC = 5'b10000
  } phase_t;

  phase_t                phase_r, phase_nxt, ph;
  logic                  neg_r, neg_nxt, neg;
  logic                  ovf_r, ovf_nxt, ovf;
  logic [INT_BITS-1:0]   int_r, int_nxt, iacc;
  logic [FRAC_NUM_W-1:0] fnum_r, fnum_nxt, fnum;
  logic [FRAC_CNT_W-1:0] fcnt_r, fcnt_nxt, fcnt;
  logic                  accept, is_digit, is_ws, fin, fin_zero;
  logic [3:0]            dval;
  logic [PROD_W-1:0]     prod;
  logic                  prod_ovf;
  logic [INT_BITS-1:0]   int_step;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;

  assign is_digit = (in_data.ch >= CH_ZERO) && (in_data.ch <= CH_NINE);
  assign is_ws    = (in_data.ch == CH_SPACE) ||
                    ((in_data.ch >= CH_TAB) && (in_data.ch <= CH_CR));
  assign dval     = 4'(in_data.ch - CH_ZERO);

  always_comb begin
    // A start marker drops anything in progress before this character is looked at.
    ph   = in_data.start_req ? PH_WS : phase_r;
    neg  = in_data.start_req ? 1'b0 : neg_r;
    ovf  = in_data.start_req ? 1'b0 : ovf_r;
    iacc = in_data.start_req ? '0 : int_r;
    fnum = in_data.start_req ? '0 : fnum_r;
    fcnt = in_data.start_req ? '0 : fcnt_r;

    prod     = (PROD_W'(iacc) << 3) + (PROD_W'(iacc) << 1) + PROD_W'(dval);
    prod_ovf = ovf || (prod[PROD_W-1:INT_BITS] != '0);
    int_step = prod_ovf ? INT_LIMIT : prod[INT_BITS-1:0];

    phase_nxt = ph;
    neg_nxt   = neg;
    ovf_nxt   = ovf;
    int_nxt   = iacc;
    fnum_nxt  = fnum;
    fcnt_nxt  = fcnt;
    fin       = 1'b0;
    fin_zero  = 1'b0;

    case (ph)
      PH_WS: begin
        if (is_ws) begin
          phase_nxt = PH_WS;
        end else if ((in_data.ch == CH_PLUS) || (in_data.ch == CH_MINUS)) begin
          neg_nxt   = (in_data.ch == CH_MINUS);
          phase_nxt = PH_SIGN;
        end else if (is_digit) begin
          int_nxt   = int_step;
          ovf_nxt   = prod_ovf;
          phase_nxt = PH_INT;
        end else if (in_data.ch == CH_DOT) begin
          phase_nxt = PH_FRAC;
        end else begin
          fin      = 1'b1;
          fin_zero = 1'b1;
        end
      end
      PH_SIGN: begin
        if (is_digit) begin
          int_nxt   = int_step;
          ovf_nxt   = prod_ovf;
          phase_nxt = PH_INT;
        end else begin
          fin      = 1'b1;
          fin_zero = 1'b1;
        end
      end
      PH_INT: begin
        if (is_digit) begin
          int_nxt = int_step;
          ovf_nxt = prod_ovf;
        end else if (in_data.ch == CH_DOT) begin
          phase_nxt = PH_FRAC;
        end else begin
          fin = 1'b1;
        end
      end
      PH_FRAC: begin
        if (is_digit) begin
          if (fcnt < FRAC_CNT_W'(MAX_FRAC_DIGITS)) begin
            fnum_nxt = (fnum << 3) + (fnum << 1) + FRAC_NUM_W'(dval);
            fcnt_nxt = fcnt + FRAC_CNT_W'(1);
          end
        end else begin
          fin = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase

    if (fin) begin
      phase_nxt = PH_IDLE;
      neg_nxt   = 1'b0;
      ovf_nxt   = 1'b0;
      int_nxt   = '0;
      fnum_nxt  = '0;
      fcnt_nxt  = '0;
    end
  end

  assign push_valid           = accept && fin;
  assign push_job.zero        = fin_zero;
  assign push_job.negative    = neg;
  assign push_job.overflow    = ovf;
  assign push_job.int_acc     = iacc;
  assign push_job.frac_num    = fnum;
  assign push_job.frac_digits = fcnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      neg_r   <= 1'b0;
      ovf_r   <= 1'b0;
      int_r   <= '0;
      fnum_r  <= '0;
      fcnt_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      ovf_r   <= ovf_nxt;
      int_r   <= int_nxt;
      fnum_r  <= fnum_nxt;
      fcnt_r  <= fcnt_nxt;
    end
  end

endmodule

[src/dtf_queue.sv]
// Short job queue between the parser and the formatter.
// Register-based, two entries. Depends on dtf_pkg.
module dtf_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  dtf_pkg::job_t push_job,
  output logic          pop_valid,
  input  logic          pop_ready,
  output dtf_pkg::job_t pop_job
);
  import dtf_pkg::*;

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push, pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue fill count beyond depth");

endmodule

[src/dtf_back.sv]
// Formatter: bit-serial fraction divider, clamp, sign and output register.
// Takes jobs from the queue and drives the result channel. Depends on dtf_pkg.
module dtf_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  dtf_pkg::job_t pop_job,
  output logic          out_valid,
  input  logic          out_ready,
  output dtf_pkg::out_t out_data
);
  import dtf_pkg::*;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_DIV  = 3'b010,
    B_FIN  = 3'b100
  } bstate_t;

  bstate_t             state_r, state_nxt;
  logic [STEP_W-1:0]   step_r;
  logic [REM_W-1:0]    rem_r, rem2;
  logic [DIV_W-1:0]    div_r;
  logic [FRAC_BITS-1:0] quo_r;
  logic [INT_BITS-1:0] int_r;
  logic                zero_r, neg_r, ovf_r;
  logic                rem_ge;
  logic [SUM_W-1:0]    sum;
  logic                sat;
  logic [VALUE_W-1:0]  mag;
  logic                load;
  logic                out_valid_r;
  out_t                out_r;

  assign pop_ready = (state_r == B_IDLE);
  assign rem2      = {rem_r[REM_W-2:0], 1'b0};
  assign rem_ge    = (rem2 >= REM_W'(div_r));
  assign load      = (state_r == B_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    sum = (SUM_W'(int_r) << FRAC_BITS) + SUM_W'(quo_r);
    sat = 1'b0;
    mag = VALUE_W'(sum);
    if (zero_r) begin
      mag = '0;
    end else if (ovf_r || (sum > MAG_CAP)) begin
      mag = VALUE_W'(MAG_CAP);
      sat = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE:  if (pop_valid) state_nxt = B_DIV;
      B_DIV:   if (step_r == STEP_W'(FRAC_BITS - 1)) state_nxt = B_FIN;
      B_FIN:   if (load) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == B_IDLE) begin
      // The kept digits are always below 10^k, so the remainder starts below the divisor.
      rem_r  <= REM_W'(pop_job.frac_num);
      div_r  <= pow10(pop_job.frac_digits);
      quo_r  <= '0;
      int_r  <= pop_job.int_acc;
      zero_r <= pop_job.zero;
      neg_r  <= pop_job.negative && !pop_job.zero;
      ovf_r  <= pop_job.overflow;
    end else if (state_r == B_DIV) begin
      rem_r <= rem_ge ? rem2 - REM_W'(div_r) : rem2;
      quo_r <= {quo_r[FRAC_BITS-2:0], rem_ge};
    end
    if (load) begin
      out_r.value     <= neg_r ? -$signed(mag) : $signed(mag);
      out_r.saturated <= sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_DIV) begin
        step_r <= step_r + STEP_W'(1);
      end else begin
        step_r <= '0;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DIV) |-> (rem_r < REM_W'(div_r)))
    else $error("divider remainder not below divisor");

  a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != B_DIV) |-> (step_r == '0))
    else $error("divider step count active outside division");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.saturated) |->
      ((out_r.value == $signed(VALUE_W'(MAG_CAP))) ||
       (out_r.value == -$signed(VALUE_W'(MAG_CAP)))))
    else $error("saturated result not at the clamp magnitude");

endmodule

[src/decimal_text_to_fixed_point.sv]
// Top level of the decimal text to fixed-point converter.
// Instantiates dtf_front, dtf_queue and dtf_back; depends on dtf_pkg.
//
// Usage: characters arrive one per transfer on the in_ channel. A transfer with
// start_req set begins a new number and drops any number still being read.
// Leading whitespace is skipped, a sign counts only when a digit follows, and the
// first character that fits no part of the number ends it. That character
// produces one transfer on the out_ channel carrying the Q31.16 value and the
// saturation flag; every other character produces nothing.
// Throughput: the parser takes one character per cycle. Each finished number
// then occupies the formatter while its bit-serial divider scales the
// fraction digits; a two-entry queue lets the parser run ahead while the
// formatter works, and in_ready drops only when that queue is full.
// The job of the terminating character passes through the queue and the
// divider into the output register.
// Reset (rst_n low, synchronous) returns the parser to idle, empties the queue
// and drops out_valid. When the receiver stalls, the result is held in the
// output register while the formatter finishes the next job behind it.
module decimal_text_to_fixed_point (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  dtf_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output dtf_pkg::out_t out_data
);
  import dtf_pkg::*;

  logic push_valid, push_ready;
  logic pop_valid, pop_ready;
  job_t push_job, pop_job;

  // Parser: classifies each character and accumulates the digits.
  dtf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  // Decouples the parser from the slower formatter.
  dtf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  // Formatter: scales the fraction, clamps, applies the sign.
  dtf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[sim/tb_decimal_text_to_fixed_point.sv]
// Self-checking testbench for the decimal text to fixed-point converter.
// Drives characters over the in_ channel and checks each Q31.16 result against a
// built-in parser model; depends on dtf_pkg and decimal_text_to_fixed_point.
module tb_decimal_text_to_fixed_point;
  import dtf_pkg::*;

  // Silent stretches are normal while the formatter works through a full queue
  // and the receiver stalls. STALL_LIMIT silent cycles in a row mean the block
  // has locked up, whatever the idling pattern happens to be.
  localparam int STALL_LIMIT = 2000;
  localparam int CHAR_TARGET = 1250;
  localparam int ROWS        = 9;

  localparam longint unsigned INT_MAX = (64'd1 << INT_BITS) - 64'd1;
  localparam longint unsigned MAG_MAX = (INT_BITS + FRAC_BITS >= VALUE_W - 1) ?
                                        (64'd1 << (VALUE_W - 1)) - 64'd1 :
                                        (64'd1 << (INT_BITS + FRAC_BITS)) - 64'd1;

  // Where the parser model stands within the current string.
  typedef enum logic [2:0] {PH_IDLE, PH_BLANK, PH_SIGN, PH_INT, PH_FRAC} parse_phase_e;

  // How the receiver behaves; it is drawn anew whenever the low byte of rx_tick is zero.
  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_LONG_STALL} rx_mode_e;

  // One directed string. Where typed is set, the value and flag given here are
  // what the terminating character must produce, and they replace the model.
  typedef struct {
    bit               lead_start;
    string            txt;
    bit               typed;
    logic [VALUE_W-1:0] val;
    bit               sat;
  } text_row_t;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  out_t out_data;

  decimal_text_to_fixed_point dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Parser model: its own copy of the string state, advanced once per accepted
  // character. Each number it closes is queued as the result to be checked.
  // ---------------------------------------------------------------------------
  parse_phase_e          txt_phase = PH_IDLE;
  bit                    txt_neg   = 1'b0;
  logic [INT_BITS-1:0]   int_part  = '0;
  logic [FRAC_NUM_W-1:0] frac_part = '0;
  logic [FRAC_CNT_W-1:0] frac_cnt  = '0;
  bit                    int_ovf   = 1'b0;

  out_t expected_numbers[$];

  task automatic forget_number();
    txt_neg   = 1'b0;
    int_part  = '0;
    frac_part = '0;
    frac_cnt  = '0;
    int_ovf   = 1'b0;
  endtask

  function automatic bit is_blank(input logic [7:0] x);
    return x == CH_SPACE || (x >= CH_TAB && x <= CH_CR);
  endfunction

  // Once the integer part has overflowed it stays pinned at the limit, even if
  // later digits would bring the product back into range.
  task automatic add_int_digit(input logic [3:0] d);
    longint unsigned nxt;
    nxt = 64'(int_part) * 64'd10 + 64'(d);
    if (int_ovf || nxt > INT_MAX) begin
      int_part = INT_MAX[INT_BITS-1:0];
      int_ovf  = 1'b1;
    end else begin
      int_part = nxt[INT_BITS-1:0];
    end
  endtask

  // The fraction is truncated towards zero before the sign is applied, so a
  // negative number is the exact negation of its magnitude.
  function automatic out_t fixed_of_number(input bit zero);
    longint unsigned mag;
    longint unsigned frac;
    longint unsigned scale;
    out_t r;
    mag         = 64'd0;
    r.saturated = 1'b0;
    if (!zero) begin
      scale = 64'd1;
      repeat (frac_cnt) scale = scale * 64'd10;
      frac = (64'(frac_part) << FRAC_BITS) / scale;
      if (int_ovf || 64'(int_part) > (MAG_MAX >> FRAC_BITS)) begin
        mag         = MAG_MAX;
        r.saturated = 1'b1;
      end else begin
        mag = (64'(int_part) << FRAC_BITS) + frac;
        if (mag > MAG_MAX) begin
          mag         = MAG_MAX;
          r.saturated = 1'b1;
        end
      end
      if (txt_neg) mag = 64'd0 - mag;
    end
    r.value = mag[VALUE_W-1:0];
    return r;
  endfunction

  task automatic close_number(input bit zero);
    expected_numbers.push_back(fixed_of_number(zero));
    txt_phase = PH_IDLE;
    forget_number();
  endtask

  task automatic parse_char(input in_t c, output bit produced);
    logic [7:0] x;
    bit         dig;
    x        = c.ch;
    dig      = (x >= CH_ZERO && x <= CH_NINE);
    produced = 1'b0;
    // A start flag always opens a fresh string, dropping any half-read one.
    if (c.start_req) begin
      forget_number();
      txt_phase = PH_BLANK;
    end
    case (txt_phase)
      PH_BLANK: begin
        if (!is_blank(x)) begin
          if (x == CH_PLUS || x == CH_MINUS) begin
            txt_neg   = (x == CH_MINUS);
            txt_phase = PH_SIGN;
          end else if (dig) begin
            add_int_digit(4'(x - CH_ZERO));
            txt_phase = PH_INT;
          end else if (x == CH_DOT) begin
            txt_phase = PH_FRAC;
          end else begin
            close_number(1'b1);
            produced = 1'b1;
          end
        end
      end
      // A sign only counts when a digit follows straight away; anything else,
      // a point included, ends the string with a zero result.
      PH_SIGN: begin
        if (dig) begin
          add_int_digit(4'(x - CH_ZERO));
          txt_phase = PH_INT;
        end else begin
          close_number(1'b1);
          produced = 1'b1;
        end
      end
      PH_INT: begin
        if (dig) begin
          add_int_digit(4'(x - CH_ZERO));
        end else if (x == CH_DOT) begin
          txt_phase = PH_FRAC;
        end else begin
          close_number(1'b0);
          produced = 1'b1;
        end
      end
      PH_FRAC: begin
        if (dig) begin
          // Digits beyond the kept precision are swallowed without effect.
          if (frac_cnt < MAX_FRAC_DIGITS && frac_cnt < 9) begin
            frac_part = FRAC_NUM_W'(64'(frac_part) * 64'd10 + 64'(x - CH_ZERO));
            frac_cnt  = frac_cnt + 1'b1;
          end
        end else begin
          close_number(1'b0);
          produced = 1'b1;
        end
      end
      default: txt_phase = PH_IDLE;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Sender: bursts of back-to-back transfers separated by random gaps. Valid is
  // only lowered at the start of a gap or after the last character, never between items of one burst.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int chars_sent = 0;

  task automatic send_char(input in_t c, output bit produced);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) :
                                                 $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    parse_char(c, produced);
    chars_sent++;
  endtask

  // Random strings are planned ahead as a list of characters, then sent.
  in_t char_plan[$];
  bit  plan_fresh;

  task automatic plan_char(input logic [7:0] x);
    char_plan.push_back('{ch: x, start_req: plan_fresh});
    plan_fresh = 1'b0;
  endtask

  task automatic plan_digits(input int n);
    repeat (n) plan_char(8'(CH_ZERO + $urandom_range(0, 9)));
  endtask

  task automatic plan_text(input string s);
    for (int i = 0; i < s.len(); i++) plan_char(s[i]);
  endtask

  // Most strings are well-formed numbers with random content, from no integer
  // digits up past the integer limit and the kept fraction precision. The rest are
  // broken strings (lone signs, cut-off strings that the next start drops) and
  // plain noise over the whole character range with random start flags.
  task automatic plan_string();
    int         kind;
    int         n;
    int         w;
    logic [7:0] t;
    plan_fresh = 1'b1;
    kind       = $urandom_range(0, 99);
    if (kind < 70) begin
      repeat ($urandom_range(0, 2)) begin
        w = $urandom_range(9, 14);
        plan_char((w == 14) ? CH_SPACE : 8'(w));
      end
      case ($urandom_range(0, 2))
        1:       plan_char(CH_PLUS);
        2:       plan_char(CH_MINUS);
        default: begin end
      endcase
      n = $urandom_range(0, 9);
      if (n == 8) begin
        if ($urandom_range(0, 1) == 1) plan_text("2147483647");
        else plan_text("2147483648");
      end else begin
        plan_digits((n == 0) ? 0 : (n <= 5) ? $urandom_range(1, 4) :
                    (n <= 7) ? $urandom_range(5, 9) : $urandom_range(10, 14));
      end
      if ($urandom_range(0, 2) != 0) begin
        plan_char(CH_DOT);
        plan_digits(($urandom_range(0, 3) == 0) ? $urandom_range(9, 13) :
                                                  $urandom_range(0, 8));
      end
      t = 8'($urandom_range(0, 255));
      if ((t >= CH_ZERO && t <= CH_NINE) || t == CH_DOT) t = ";";
      plan_char(t);
    end else if (kind < 85) begin
      case ($urandom_range(0, 2))
        0: begin
          plan_char(($urandom_range(0, 1) == 1) ? CH_MINUS : CH_PLUS);
          plan_char(($urandom_range(0, 1) == 1) ? CH_DOT : CH_SPACE);
          plan_digits(1);
          plan_char(CH_SPACE);
        end
        1: plan_digits($urandom_range(1, 6));
        default: begin
          plan_char(CH_PLUS);
          plan_char(CH_MINUS);
          plan_digits(1);
          plan_char(CH_SPACE);
        end
      endcase
    end else begin
      repeat ($urandom_range(1, 6)) begin
        char_plan.push_back('{ch: 8'($urandom_range(0, 255)),
                              start_req: 1'($urandom_range(0, 1))});
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: its ready pattern is redrawn whenever the low byte of rx_tick is zero,
  // among always ready, coin-flip, mostly stalled, and a regular stall on rx_tick.
  // ---------------------------------------------------------------------------
  logic [15:0] rx_tick = '0;
  rx_mode_e    rx_mode = RX_OPEN;

  always @(posedge clk) begin
    rx_tick <= rx_tick + 1'b1;
    if (rx_tick[7:0] == 8'd0) rx_mode <= rx_mode_e'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default:   out_ready <= (rx_tick[4:0] >= 5'd24);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result checker and watchdog. Every output transfer is matched against the
  // oldest number still waiting; the silent-cycle count feeds the watchdog.
  // ---------------------------------------------------------------------------
  int errors       = 0;
  int numbers_seen = 0;
  int clamped_seen = 0;
  int idle_cycles  = 0;

  always @(posedge clk) begin
    out_t want;
    if (rst_n) begin
      idle_cycles <= ((in_valid && in_ready) || (out_valid && out_ready)) ? 0 :
                     idle_cycles + 1;
      if (out_valid && out_ready) begin
        if (expected_numbers.size() == 0) begin
          $error("unexpected result transfer: value %0d saturated %0b",
                 out_data.value, out_data.saturated);
          errors++;
        end else begin
          want = expected_numbers.pop_front();
          numbers_seen++;
          if (want.saturated) clamped_seen++;
          if (out_data.value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, out_data.value);
            errors++;
          end
          if (out_data.saturated !== want.saturated) begin
            $error("saturated: expected %0b, got %0b", want.saturated,
                   out_data.saturated);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $error("no transfer in %0d cycles, %0d results outstanding", STALL_LIMIT,
           expected_numbers.size());
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus: a short directed table, then random strings.
  // ---------------------------------------------------------------------------
  text_row_t directed_rows [0:ROWS-1];

  initial begin
    text_row_t row;
    in_t       c;
    bit        made;

    // A stray character before any start flag must be ignored.
    directed_rows[0] = '{1'b0, "Q", 1'b0, 48'h0, 1'b0};
    // Negative zero comes out as plain zero.
    directed_rows[1] = '{1'b1, "-0,", 1'b1, 48'h0, 1'b0};
    directed_rows[2] = '{1'b1, "-1;", 1'b1, 48'hFFFF_FFFF_0000, 1'b0};
    // A sign followed by a point is not a number at all.
    directed_rows[3] = '{1'b1, "+.", 1'b1, 48'h0, 1'b0};
    // A leading point starts the fraction: one half.
    directed_rows[4] = '{1'b1, ".5 ", 1'b1, 48'h0000_0000_8000, 1'b0};
    // Cut off without a terminator; the next start drops it silently.
    directed_rows[5] = '{1'b1, "12", 1'b0, 48'h0, 1'b0};
    // One past the integer limit clamps to the largest negative magnitude.
    directed_rows[6] = '{1'b1, "-2147483648 ", 1'b1, 48'h8000_0000_0001, 1'b1};
    // Leading whitespace is skipped.
    directed_rows[7] = '{1'b1, "\t\v7x", 1'b1, 48'h0000_0007_0000, 1'b0};
    // No digits gives zero; the trailing characters then arrive with no string open.
    directed_rows[8] = '{1'b1, "abc", 1'b1, 48'h0, 1'b0};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < ROWS; i++) begin
      row = directed_rows[i];
      for (int j = 0; j < row.txt.len(); j++) begin
        c.ch        = row.txt[j];
        c.start_req = row.lead_start && (j == 0);
        send_char(c, made);
        if (made && row.typed) begin
          expected_numbers[expected_numbers.size() - 1] = '{value: row.val,
                                                             saturated: row.sat};
        end
      end
    end

    while (chars_sent < CHAR_TARGET) begin
      plan_string();
      while (char_plan.size() != 0) send_char(char_plan.pop_front(), made);
    end
    in_valid <= 1'b0;

    // Drain, then leave room for any stray result to show up.
    while (expected_numbers.size() != 0) @(posedge clk);
    repeat (3 * (FRAC_BITS + 3)) @(posedge clk);

    $display("Sent %0d characters; checked %0d numbers, %0d of them clamped.",
             chars_sent, numbers_seen, clamped_seen);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches found.", errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[decimal_text_to_fixed_point.f]
src/dtf_pkg.sv
src/dtf_front.sv
src/dtf_queue.sv
src/dtf_back.sv
src/decimal_text_to_fixed_point.sv
sim/tb_decimal_text_to_fixed_point.sv
